>>> hdl/waveform_pulse_feature_extract_assert.svh
// Assertion macros used by the checker of the pulse feature extractor.
// No dependencies.
`ifndef WAVEFORM_PULSE_FEATURE_EXTRACT_ASSERT_SVH
`define WAVEFORM_PULSE_FEATURE_EXTRACT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WPFE_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define WPFE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hdl/wpfe_pkg.sv
// Shared types and constants of the pulse feature extractor.
// No dependencies.
`timescale 1ns / 1ps
package wpfe_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 23;
  localparam int IDX_W     = 7;
  localparam int CH_W      = 3;
  localparam int EVT_W     = 32;
  localparam int FRAC_W    = 8;
  localparam int FIX_W     = 24;
  localparam int CHG_W     = 30;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_CHANNELS = 8;

  localparam int CHANNELS_DEF       = 8;
  localparam int RECORD_SAMPLES_DEF = 100;
  localparam int WINDOW_START_DEF   = 30;
  localparam int WINDOW_END_DEF     = 50;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd550;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 1'd1;

  typedef struct packed {
    logic [SUM_W-1:0]    bsum;
    logic [SUM_W-1:0]    wsum;
    logic [SAMPLE_W-1:0] ext;
    logic [IDX_W-1:0]    eidx;
    logic                seen;
    logic                over;
  } lane_st_t;

endpackage

>>> hdl/wpfe_lane.sv
// One channel lane: baseline and window sums, extreme sample tracking, threshold flag.
// Depends on wpfe_pkg.
`timescale 1ns / 1ps
module wpfe_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic                         clr_i,
  input  logic                         in_win_i,
  input  logic [wpfe_pkg::IDX_W-1:0]   idx_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         pol_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0] thr_i,
  output wpfe_pkg::lane_st_t           nxt_o
);
  import wpfe_pkg::*;

  lane_st_t st_q, st_d;
  logic     better;

  always_comb begin
    better = pol_i ? (sample_i > st_q.ext) : (sample_i < st_q.ext);
    st_d   = st_q;
    if (upd_i) begin
      if (in_win_i) begin
        st_d.wsum = st_q.wsum + SUM_W'(sample_i);
      end else begin
        st_d.bsum = st_q.bsum + SUM_W'(sample_i);
      end
      if (sample_i > thr_i) begin
        st_d.over = 1'b1;
      end
      if (!st_q.seen || better) begin
        st_d.ext  = sample_i;
        st_d.eidx = idx_i;
        st_d.seen = 1'b1;
      end
    end
  end

  assign nxt_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (clr_i) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

>>> hdl/wpfe_merge.sv
// Merge stage: holds the lane snapshot of a finished event and turns it into one result per
// cycle unless stalled, in a pipeline (pedestal divide, peak, charge). Depends on wpfe_pkg.
`timescale 1ns / 1ps
module wpfe_merge #(
  parameter int CHANNELS       = wpfe_pkg::CHANNELS_DEF,
  parameter int RECORD_SAMPLES = wpfe_pkg::RECORD_SAMPLES_DEF,
  parameter int WINDOW_START   = wpfe_pkg::WINDOW_START_DEF,
  parameter int WINDOW_END     = wpfe_pkg::WINDOW_END_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  wpfe_pkg::lane_st_t              lanes_i [CHANNELS],
  input  logic [wpfe_pkg::EVT_W-1:0]      evn_i,
  input  logic                            pol_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wpfe_pkg::CH_W-1:0]       channel_o,
  output logic [wpfe_pkg::EVT_W-1:0]      event_number_o,
  output logic [wpfe_pkg::FIX_W-1:0]      pedestal_o,
  output logic [wpfe_pkg::FIX_W-1:0]      peak_height_o,
  output logic [wpfe_pkg::IDX_W-1:0]      peak_time_o,
  output logic signed [wpfe_pkg::CHG_W-1:0] charge_o,
  output logic                            over_threshold_o,
  output logic                            last_channel_o
);
  import wpfe_pkg::*;

  localparam int WE = (WINDOW_END > RECORD_SAMPLES) ? RECORD_SAMPLES : WINDOW_END;
  localparam int WS = (WINDOW_START > WE) ? WE : WINDOW_START;
  localparam int NW = WE - WS;
  localparam int NB = RECORD_SAMPLES - NW;
  localparam int NB_SAFE = (NB == 0) ? 1 : NB;
  localparam bit NB_ZERO = (NB == 0);
  localparam int RECIP_SH = 31 - FRAC_W;
  localparam int RECIP_W  = 32;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int EST_W    = PROD_W - RECIP_SH;
  localparam int M_W      = EST_W + IDX_W;
  localparam int NWP_W    = FIX_W + IDX_W;
  localparam int Q_W      = CHG_W + 4;
  localparam int CIW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 31) / NB_SAFE);
  localparam logic [IDX_W-1:0]   NB_C  = IDX_W'(NB);
  localparam logic [IDX_W-1:0]   NW_C  = IDX_W'(NW);
  localparam logic [CH_W-1:0]    LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W-CHG_W+1){1'b0}}, {(CHG_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W-CHG_W+1){1'b1}}, {(CHG_W-1){1'b0}}};

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             last;
    logic [EVT_W-1:0] evn;
    lane_st_t         st;
  } meta_t;

  lane_st_t         buf_q [CHANNELS];
  logic [EVT_W-1:0] evn_q;
  logic             busy_q;
  logic [CH_W-1:0]  iss_q;
  logic             en;

  logic              v1_q, v2_q, v3_q, v4_q, out_valid_q;
  meta_t             m1_q, m2_q, m3_q, m4_q;
  logic [PROD_W-1:0] prod_q;
  logic [EST_W-1:0]  est_q;
  logic [M_W-1:0]    mul_q;
  logic [FIX_W-1:0]  ped3_q, ped4_q, peak4_q;
  logic [IDX_W-1:0]  ptime4_q;
  logic [NWP_W-1:0]  nwped4_q;

  logic [EST_W-1:0]     est_d;
  logic [M_W-1:0]       num, rem;
  logic [EST_W-1:0]     ped_full;
  logic [FIX_W-1:0]     ped_d;
  logic [FIX_W-1:0]     ext24;
  logic                 take;
  logic signed [Q_W-1:0] win_s, nwp_s, diff, qn;
  logic signed [CHG_W-1:0] q_sat;

  assign en     = !out_valid_q || !out_stall_i;
  assign busy_o = busy_q;

  // snapshot and issue
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= lanes_i;
      evn_q <= evn_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iss_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      iss_q  <= '0;
    end else if (busy_q && en) begin
      if (iss_q == LAST_CH) begin
        busy_q <= 1'b0;
        iss_q  <= '0;
      end else begin
        iss_q <= iss_q + 1'b1;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= busy_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // pedestal divide by constant: reciprocal multiply, then one correction step
  assign est_d = prod_q[PROD_W-1:RECIP_SH];
  assign num   = M_W'({m2_q.st.bsum, {FRAC_W{1'b0}}});
  assign rem   = num - mul_q;

  always_comb begin
    ped_full = est_q + EST_W'(rem >= M_W'(NB_C));
    if (NB_ZERO) begin
      ped_d = '0;
    end else if (|ped_full[EST_W-1:FIX_W]) begin
      ped_d = '1;
    end else begin
      ped_d = ped_full[FIX_W-1:0];
    end
  end

  assign ext24 = {m3_q.st.ext, {FRAC_W{1'b0}}};
  assign take  = m3_q.st.seen && (pol_i ? (ext24 > ped3_q) : (ext24 < ped3_q));

  always_comb begin
    win_s = $signed(Q_W'({m4_q.st.wsum, {FRAC_W{1'b0}}}));
    nwp_s = $signed(Q_W'(nwped4_q));
    diff  = win_s - nwp_s;
    qn    = pol_i ? diff : -diff;
    if (qn > Q_MAX) begin
      q_sat = Q_MAX[CHG_W-1:0];
    end else if (qn < Q_MIN) begin
      q_sat = Q_MIN[CHG_W-1:0];
    end else begin
      q_sat = qn[CHG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q.ch   <= iss_q;
      m1_q.last <= (iss_q == LAST_CH);
      m1_q.evn  <= evn_q;
      m1_q.st   <= buf_q[iss_q[CIW-1:0]];
      prod_q    <= PROD_W'(buf_q[iss_q[CIW-1:0]].bsum) * PROD_W'(RECIP);

      m2_q  <= m1_q;
      est_q <= est_d;
      mul_q <= M_W'(est_d) * M_W'(NB_C);

      m3_q   <= m2_q;
      ped3_q <= ped_d;

      m4_q     <= m3_q;
      ped4_q   <= ped3_q;
      peak4_q  <= take ? ext24 : ped3_q;
      ptime4_q <= take ? m3_q.st.eidx : '0;
      nwped4_q <= NWP_W'(NW_C) * NWP_W'(ped3_q);

      channel_o        <= m4_q.ch;
      event_number_o   <= m4_q.evn;
      pedestal_o       <= ped4_q;
      peak_height_o    <= peak4_q;
      peak_time_o      <= ptime4_q;
      charge_o         <= q_sat;
      over_threshold_o <= m4_q.st.over;
      last_channel_o   <= m4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/waveform_pulse_feature_extract.sv
// Channel      | Handshake               | Beat
// sample in    | in_valid_i / in_stall_o | eight channel samples, end_of_event
// result out   | out_valid_o / out_stall_i | one channel's pulse features
// config write | cfg_valid_i / cfg_ready_o | register index and data
//
// One sample beat per cycle unless stalled; lanes update in the cycle of acceptance.
// At end of event the lanes are copied to the merge buffer, which issues one channel
// per cycle, unless the output stalls, into a five-stage pipeline.
// An end-of-event beat stalls until the previous event's CHANNELS results are issued.
// Async active-low reset clears lanes and counters, presets config; no clearing pass.
// Depends on wpfe_pkg, wpfe_lane, wpfe_merge.
`timescale 1ns / 1ps
module waveform_pulse_feature_extract #(
  parameter int CHANNELS       = wpfe_pkg::CHANNELS_DEF,
  parameter int RECORD_SAMPLES = wpfe_pkg::RECORD_SAMPLES_DEF,
  parameter int WINDOW_START   = wpfe_pkg::WINDOW_START_DEF,
  parameter int WINDOW_END     = wpfe_pkg::WINDOW_END_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch0_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch1_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch2_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch3_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch4_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch5_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch6_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    sample_ch7_i,
  input  logic                             end_of_event_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wpfe_pkg::CH_W-1:0]        channel_o,
  output logic [wpfe_pkg::EVT_W-1:0]       event_number_o,
  output logic [wpfe_pkg::FIX_W-1:0]       pedestal_o,
  output logic [wpfe_pkg::FIX_W-1:0]       peak_height_o,
  output logic [wpfe_pkg::IDX_W-1:0]       peak_time_o,
  output logic signed [wpfe_pkg::CHG_W-1:0] charge_o,
  output logic                             over_threshold_o,
  output logic                             last_channel_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wpfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wpfe_pkg::SAMPLE_W-1:0]    cfg_data_i
);
  import wpfe_pkg::*;

  localparam int WE = (WINDOW_END > RECORD_SAMPLES) ? RECORD_SAMPLES : WINDOW_END;
  localparam int WS = (WINDOW_START > WE) ? WE : WINDOW_START;
  localparam logic [IDX_W-1:0] RS_C = IDX_W'(RECORD_SAMPLES);
  localparam logic [IDX_W-1:0] WS_C = IDX_W'(WS);
  localparam logic [IDX_W-1:0] WE_C = IDX_W'(WE);

  logic [SAMPLE_W-1:0] thr_q;
  logic                pol_q;
  logic [IDX_W-1:0]    idx_q;
  logic [EVT_W-1:0]    evn_q;
  logic                accept, in_rec, in_win, busy;
  logic [SAMPLE_W-1:0] samples [MAX_CHANNELS];
  lane_st_t            lane_nxt [CHANNELS];

  assign samples[0] = sample_ch0_i;
  assign samples[1] = sample_ch1_i;
  assign samples[2] = sample_ch2_i;
  assign samples[3] = sample_ch3_i;
  assign samples[4] = sample_ch4_i;
  assign samples[5] = sample_ch5_i;
  assign samples[6] = sample_ch6_i;
  assign samples[7] = sample_ch7_i;

  assign in_stall_o  = busy && end_of_event_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_rec      = idx_q < RS_C;
  assign in_win      = (idx_q >= WS_C) && (idx_q < WE_C);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      pol_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_THRESHOLD: thr_q <= cfg_data_i;
        REG_POLARITY:  pol_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      evn_q <= '0;
    end else if (accept) begin
      if (end_of_event_i) begin
        idx_q <= '0;
        evn_q <= evn_q + 1'b1;
      end else if (in_rec) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    wpfe_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .upd_i    (accept && in_rec),
      .clr_i    (accept && end_of_event_i),
      .in_win_i (in_win),
      .idx_i    (idx_q),
      .sample_i (samples[c]),
      .pol_i    (pol_q),
      .thr_i    (thr_q),
      .nxt_o    (lane_nxt[c])
    );
  end

  wpfe_merge #(
    .CHANNELS       (CHANNELS),
    .RECORD_SAMPLES (RECORD_SAMPLES),
    .WINDOW_START   (WINDOW_START),
    .WINDOW_END     (WINDOW_END)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept && end_of_event_i),
    .lanes_i          (lane_nxt),
    .evn_i            (evn_q),
    .pol_i            (pol_q),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_o        (channel_o),
    .event_number_o   (event_number_o),
    .pedestal_o       (pedestal_o),
    .peak_height_o    (peak_height_o),
    .peak_time_o      (peak_time_o),
    .charge_o         (charge_o),
    .over_threshold_o (over_threshold_o),
    .last_channel_o   (last_channel_o)
  );

endmodule

>>> hdl/wpfe_checker.sv
// Port-level checks of the pulse feature extractor, bound to the top level.
// Depends on wpfe_pkg and waveform_pulse_feature_extract_assert.svh.
`timescale 1ns / 1ps
`include "waveform_pulse_feature_extract_assert.svh"
module wpfe_checker #(
  parameter int CHANNELS = wpfe_pkg::CHANNELS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [wpfe_pkg::CH_W-1:0]        channel_o,
  input logic [wpfe_pkg::EVT_W-1:0]       event_number_o,
  input logic [wpfe_pkg::FIX_W-1:0]       pedestal_o,
  input logic [wpfe_pkg::FIX_W-1:0]       peak_height_o,
  input logic [wpfe_pkg::IDX_W-1:0]       peak_time_o,
  input logic                             last_channel_o
);
  import wpfe_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic beat_out;
  assign beat_out = out_valid_o && !out_stall_i;

  `WPFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(channel_o) && $stable(pedestal_o))
  `WPFE_ASSERT_SAME(a_last_ch, clk_i, rst_ni, out_valid_o, last_channel_o == (channel_o == LAST_CH))
  `WPFE_ASSERT_SAME(a_peak_found, clk_i, rst_ni, out_valid_o && (peak_time_o != '0), peak_height_o != pedestal_o)
  `WPFE_ASSERT_NEXT(a_evn_hold, clk_i, rst_ni, beat_out && !last_channel_o, $stable(event_number_o))

endmodule

bind waveform_pulse_feature_extract wpfe_checker #(.CHANNELS(CHANNELS)) u_wpfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .channel_o      (channel_o),
  .event_number_o (event_number_o),
  .pedestal_o     (pedestal_o),
  .peak_height_o  (peak_height_o),
  .peak_time_o    (peak_time_o),
  .last_channel_o (last_channel_o)
);

>>> bench/tb_waveform_pulse_feature_extract.sv
// Self-checking bench for waveform_pulse_feature_extract: sample beats in, per-channel
// pulse features out, compared against a behavioral feature predictor kept in the bench.
// Depends on wpfe_pkg and the waveform_pulse_feature_extract RTL.
`timescale 1ns / 1ps
module tb_waveform_pulse_feature_extract;
  import wpfe_pkg::*;

  localparam int NCH    = CHANNELS_DEF;
  localparam int REC    = RECORD_SAMPLES_DEF;
  localparam int WIN_E  = (WINDOW_END_DEF > REC) ? REC : WINDOW_END_DEF;
  localparam int WIN_S  = (WINDOW_START_DEF > WIN_E) ? WIN_E : WINDOW_START_DEF;
  localparam int NWIN   = WIN_E - WIN_S;
  localparam int NBASE  = REC - NWIN;
  localparam int SETTLE = 12;
  localparam int WATCHDOG = 4000;
  localparam int DIR_N  = 12;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 25;
  localparam int LONG_PHASE = 3;
  localparam int MAX_REPORTS = 10;

  typedef enum int {SHAPE_PULSE, SHAPE_NOISE, SHAPE_RAIL} shape_e;

  typedef struct packed {
    logic [NCH-1:0][SAMPLE_W-1:0] smp;
    logic                         eoe;
  } beat_t;

  typedef struct packed {
    logic                    on;
    logic [FIX_W-1:0]        ped;
    logic [FIX_W-1:0]        peak;
    logic [IDX_W-1:0]        ptime;
    logic signed [CHG_W-1:0] chg;
    logic                    over;
  } known_t;

  typedef struct packed {
    logic [CH_W-1:0]         chan;
    logic [EVT_W-1:0]        evt;
    logic [FIX_W-1:0]        ped;
    logic [FIX_W-1:0]        peak;
    logic [IDX_W-1:0]        ptime;
    logic signed [CHG_W-1:0] chg;
    logic                    over;
    logic                    last;
  } pulse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  beat_t beat_q = '0;
  known_t known_q = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  logic in_stall, out_valid, cfg_ready;
  logic [CH_W-1:0] channel;
  logic [EVT_W-1:0] event_number;
  logic [FIX_W-1:0] pedestal, peak_height;
  logic [IDX_W-1:0] peak_time;
  logic signed [CHG_W-1:0] charge;
  logic over_threshold, last_channel;
  logic any_beat;

  waveform_pulse_feature_extract dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_ch0_i     (beat_q.smp[0]),
    .sample_ch1_i     (beat_q.smp[1]),
    .sample_ch2_i     (beat_q.smp[2]),
    .sample_ch3_i     (beat_q.smp[3]),
    .sample_ch4_i     (beat_q.smp[4]),
    .sample_ch5_i     (beat_q.smp[5]),
    .sample_ch6_i     (beat_q.smp[6]),
    .sample_ch7_i     (beat_q.smp[7]),
    .end_of_event_i   (beat_q.eoe),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .channel_o        (channel),
    .event_number_o   (event_number),
    .pedestal_o       (pedestal),
    .peak_height_o    (peak_height),
    .peak_time_o      (peak_time),
    .charge_o         (charge),
    .over_threshold_o (over_threshold),
    .last_channel_o   (last_channel),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [SUM_W-1:0]    base_acc [NCH];
  logic [20:0]         win_acc  [NCH];
  logic [SAMPLE_W-1:0] ext_val  [NCH];
  logic [IDX_W-1:0]    ext_idx  [NCH];
  logic                ext_seen [NCH];
  logic                over_hit [NCH];
  logic [IDX_W-1:0]    cur_idx = '0;
  logic [EVT_W-1:0]    evt_cnt = '0;
  logic [SAMPLE_W-1:0] thr_r = THRESHOLD_RST;
  logic                pol_r = 1'b0;

  pulse_t feature_q[$];

  int fails = 0;
  int idle_cycles = 0;
  int beats_seen = 0;
  int events_seen = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int stall_run = 0;
  int gap_len = 0;
  int gen_pos = 0;

  assign any_beat = (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
                    (out_valid && !out_stall);

  initial begin
    for (int c = 0; c < NCH; c++) begin
      base_acc[c] = '0;
      win_acc[c] = '0;
      ext_val[c] = '0;
      ext_idx[c] = '0;
      ext_seen[c] = 1'b0;
      over_hit[c] = 1'b0;
    end
  end

  task automatic extract_features(input beat_t b, input known_t k);
    longint ped, ext, q;
    logic [SAMPLE_W-1:0] v;
    logic in_win;
    pulse_t r;
    if (int'(cur_idx) < REC) begin
      in_win = (int'(cur_idx) >= WIN_S) && (int'(cur_idx) < WIN_E);
      for (int c = 0; c < NCH; c++) begin
        v = b.smp[c];
        if (in_win) win_acc[c] = win_acc[c] + v;
        else base_acc[c] = base_acc[c] + v;
        if (v > thr_r) over_hit[c] = 1'b1;
        if (!ext_seen[c] || (pol_r ? (v > ext_val[c]) : (v < ext_val[c]))) begin
          ext_val[c] = v;
          ext_idx[c] = cur_idx;
          ext_seen[c] = 1'b1;
        end
      end
      cur_idx = cur_idx + 1'b1;
    end
    if (b.eoe) begin
      for (int c = 0; c < NCH; c++) begin
        ped = 0;
        if (NBASE != 0) ped = (longint'(base_acc[c]) << 8) / NBASE;
        if (ped > 64'hFF_FFFF) ped = 64'hFF_FFFF;
        ext = longint'(ext_val[c]) << 8;
        r.chan = CH_W'(c);
        r.evt = evt_cnt;
        r.ped = FIX_W'(ped);
        r.peak = FIX_W'(ped);
        r.ptime = '0;
        if (ext_seen[c] && (pol_r ? (ext > ped) : (ext < ped))) begin
          r.peak = FIX_W'(ext);
          r.ptime = ext_idx[c];
        end
        q = (longint'(win_acc[c]) << 8) - longint'(NWIN) * ped;
        if (!pol_r) q = -q;
        if (q > 536870911) q = 536870911;
        if (q < -536870912) q = -536870912;
        r.chg = CHG_W'(q);
        r.over = over_hit[c];
        r.last = (c == NCH - 1);
        if (k.on) begin
          r.ped = k.ped;
          r.peak = k.peak;
          r.ptime = k.ptime;
          r.chg = k.chg;
          r.over = k.over;
        end
        feature_q.push_back(r);
        base_acc[c] = '0;
        win_acc[c] = '0;
        ext_val[c] = '0;
        ext_idx[c] = '0;
        ext_seen[c] = 1'b0;
        over_hit[c] = 1'b0;
      end
      evt_cnt = evt_cnt + 1'b1;
      cur_idx = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input pulse_t e, input pulse_t g);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%s at %0t", what, $realtime);
      $display("  exp ch=%0d evt=%0d ped=%h peak=%h t=%0d q=%0d ov=%0d last=%0d",
               e.chan, e.evt, e.ped, e.peak, e.ptime, e.chg, e.over, e.last);
      $display("  got ch=%0d evt=%0d ped=%h peak=%h t=%0d q=%0d ov=%0d last=%0d",
               g.chan, g.evt, g.ped, g.peak, g.ptime, g.chg, g.over, g.last);
    end
  endtask

  task automatic check_result();
    pulse_t got, exp;
    got.chan = channel;
    got.evt = event_number;
    got.ped = pedestal;
    got.peak = peak_height;
    got.ptime = peak_time;
    got.chg = charge;
    got.over = over_threshold;
    got.last = last_channel;
    if (feature_q.size() == 0) begin
      report_mismatch("result with nothing pending", '0, got);
    end else begin
      exp = feature_q.pop_front();
      if (got.chan !== exp.chan || got.evt !== exp.evt || got.ped !== exp.ped ||
          got.peak !== exp.peak || got.ptime !== exp.ptime || got.chg !== exp.chg ||
          got.over !== exp.over || got.last !== exp.last)
        report_mismatch("feature mismatch", exp, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles <= any_beat ? 0 : idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r = cfg_data;
          REG_POLARITY:  pol_r = cfg_data[0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        extract_features(beat_q, known_q);
        beats_seen++;
        if (beat_q.eoe) events_seen++;
      end
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 6);
    end else begin
      gap_len = pick_gap();
      if (gap_len > 0) begin
        out_stall <= 1'b1;
        stall_run <= gap_len - 1;
      end else begin
        stall_run <= $urandom_range(0, 4);
      end
    end
  end

  task automatic send_beat(input beat_t b, input known_t k, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    beat_q <= b;
    known_q <= k;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (feature_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [SAMPLE_W-1:0] thr, input logic pol);
    cfg_valid <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_POLARITY;
    cfg_data <= {{(SAMPLE_W-1){1'b0}}, pol};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [NCH-1:0][SAMPLE_W-1:0] spread(input int base, input int step);
    logic [NCH-1:0][SAMPLE_W-1:0] r;
    for (int c = 0; c < NCH; c++) r[c] = SAMPLE_W'(base + c * step);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] shape_sample(input shape_e mode, input int pos,
                                                       input int base, input int amp,
                                                       input logic up);
    int v;
    case (mode)
      SHAPE_NOISE: v = $urandom_range(0, 65535);
      SHAPE_RAIL:  v = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 65535) :
                       ($urandom_range(0, 1) ? 65535 : 0);
      default: begin
        v = base + $urandom_range(0, 15);
        if (pos >= WIN_S + 2 && pos < WIN_S + 12) v = up ? v + amp : v - amp;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return SAMPLE_W'(v);
  endfunction

  task automatic run_event(input int len, input logic close, inout int counted);
    shape_e mode_c [NCH];
    int base_c [NCH];
    int amp_c [NCH];
    logic up_c [NCH];
    int r;
    beat_t b;
    for (int c = 0; c < NCH; c++) begin
      r = $urandom_range(0, 99);
      mode_c[c] = (r < 70) ? SHAPE_PULSE : (r < 88) ? SHAPE_NOISE : SHAPE_RAIL;
      base_c[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) :
                  $urandom_range(200, 3000);
      amp_c[c] = $urandom_range(0, 60000);
      up_c[c] = ($urandom_range(0, 4) == 0) ? !pol_r : pol_r;
    end
    for (int i = 0; i < len; i++) begin
      for (int c = 0; c < NCH; c++)
        b.smp[c] = shape_sample(mode_c[c], gen_pos, base_c[c], amp_c[c], up_c[c]);
      b.eoe = close && (i == len - 1);
      send_beat(b, '0, pick_gap());
      if (gen_pos < REC) counted++;
      gen_pos = b.eoe ? 0 : gen_pos + 1;
    end
  endtask

  beat_t  dir_beat [DIR_N];
  known_t dir_known [DIR_N];

  initial begin
    int items, len, r;
    logic [SAMPLE_W-1:0] thr;
    logic pol;

    for (int i = 0; i < DIR_N; i++) begin
      dir_beat[i] = '0;
      dir_known[i] = '0;
    end
    // single-beat events: all zero, all full scale, per-channel threshold edges
    dir_beat[0].smp = spread(0, 0);
    dir_beat[0].eoe = 1'b1;
    dir_known[0].on = 1'b1;
    dir_beat[1].smp = spread(16'hFFFF, 0);
    dir_beat[1].eoe = 1'b1;
    dir_known[1].on = 1'b1;
    dir_known[1].ped = 24'd209712;
    dir_known[1].peak = 24'd209712;
    dir_known[1].chg = 30'sd4194240;
    dir_known[1].over = 1'b1;
    dir_beat[2].smp = {16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                       16'd551, 16'd550, 16'd1, 16'd0};
    dir_beat[2].eoe = 1'b1;
    // short event with a dip, then one with tied extremes
    dir_beat[3].smp = spread(800, 100);
    dir_beat[4].smp = spread(300, 50);
    dir_beat[5].smp = spread(300, 50);
    dir_beat[6].smp = spread(900, 0);
    dir_beat[6].eoe = 1'b1;
    dir_beat[7].smp = spread(500, 0);
    dir_beat[8].smp = spread(100, 1);
    dir_beat[9].smp = spread(100, 1);
    dir_beat[10].smp = spread(65535, -4000);
    dir_beat[11].smp = spread(2000, 3000);
    dir_beat[11].eoe = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) send_beat(dir_beat[i], dir_known[i], pick_gap());
    settle_block();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin thr = 16'd0;     pol = 1'b1; end
        1: begin thr = 16'hFFFF;  pol = 1'b0; end
        2: begin thr = 16'hFFFF;  pol = 1'b1; end
        3: begin thr = 16'd0;     pol = 1'b0; end
        default: begin
          thr = SAMPLE_W'($urandom_range(0, 65535));
          pol = $urandom_range(0, 1);
        end
      endcase
      write_config(thr, pol);
      items = 0;
      // run past the end of the record once
      if (p == LONG_PHASE) run_event($urandom_range(REC + 1, REC + 10), 1'b1, items);
      while (items < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        len = (r < 60) ? $urandom_range(1, 12) :
              (r < 90) ? $urandom_range(30, 60) : $urandom_range(95, 110);
        if (len > PHASE_BEATS - items) len = PHASE_BEATS - items;
        run_event(len, 1'b1, items);
      end
      // leave an event open so the next setting lands mid-event
      if (p % 3 == 1) run_event($urandom_range(5, 40), 1'b0, items);
      settle_block();
    end

    $display("run covered %0d sample beats in %0d events, %0d channel results checked",
             beats_seen, events_seen, results_seen);
    $display("%0d register writes over %0d settings, %0d mismatches",
             cfg_writes, PHASES + 1, fails);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/wpfe_pkg.sv
hdl/wpfe_lane.sv
hdl/wpfe_merge.sv
hdl/waveform_pulse_feature_extract.sv
hdl/wpfe_checker.sv
bench/tb_waveform_pulse_feature_extract.sv
